// ===== sv/kbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbt_pkg
// Shared types and constants of the key binding table: item field widths,
// operation and status codes, table entry layout, controller state and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package kbt_pkg;

  localparam int FUNC_W      = 2;
  localparam int SYM_W       = 16;
  localparam int MOD_W       = 8;
  localparam int CMD_W       = 6;
  localparam int STATUS_W    = 2;
  localparam int TOT_W       = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (CMD_W + SYM_W + MOD_W + 1 + TOT_W);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_LIST   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_REPLACED = 2'd0,
    ST_APPENDED = 2'd1,
    ST_FULL     = 2'd2,
    ST_QUERY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [MOD_W-1:0] mods;
    logic [SYM_W-1:0] sym;
  } key_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    key_t             key;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic stop;
    logic last;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/key_binding_table_unit.sv =====
`timescale 1ns / 1ps
// The scan reads one table entry per cycle through the single memory read port and
// ends early on a match or on an add with an out-of-range command. A new input
// item is accepted only while idle, once every result of the last item is emitted.
// Reset: synchronous, active low; clears the entry count, table contents stay
// undefined until written.
// ----------------------------------------------------------------------------
// key_binding_table_unit
// Ordered key binding table with add, lookup and list operations, built as a
// sequencing controller and a scanning datapath.
// ----------------------------------------------------------------------------
module key_binding_table_unit #(
  parameter int TABLE_DEPTH     = 64,
  parameter int MAX_PER_COMMAND = 3,
  parameter int NUM_COMMANDS    = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // key_symbol[15:0], key_modifiers[23:16], command_code[29:24], zero pad
  input  logic [kbt_pkg::IN_TDATA_W-1:0]    in_tdata,
  // func[1:0]
  input  logic [kbt_pkg::FUNC_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // found_command[5:0], bound_symbol[21:6], bound_modifiers[29:22],
  // binding_valid[30], binding_total[32:31], zero pad
  output logic [kbt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // status[1:0]
  output logic [kbt_pkg::STATUS_W-1:0]      out_tuser,
  output logic                              out_tlast
);
  import kbt_pkg::*;

  func_t  in_func;
  ctrl_t  ctrl;
  stat_t  stat;

  assign in_func = func_t'(in_tuser);

  kbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_func),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  kbt_datapath #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .MAX_PER_COMMAND (MAX_PER_COMMAND),
    .NUM_COMMANDS    (NUM_COMMANDS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_func      (in_func),
    .in_symbol    (in_tdata[SYM_W-1:0]),
    .in_modifiers (in_tdata[SYM_W+MOD_W-1:SYM_W]),
    .in_command   (in_tdata[SYM_W+MOD_W+CMD_W-1:SYM_W+MOD_W]),
    .ctrl         (ctrl),
    .stat         (stat),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast)
  );

endmodule

// ===== sv/kbt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbt_ctrl
// Operation sequencer: accept an item, run the table scan, commit the table
// update, then hand result items to the output register one at a time.
// ----------------------------------------------------------------------------
module kbt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  kbt_pkg::func_t  in_func,
  input  kbt_pkg::stat_t  stat,
  output kbt_pkg::ctrl_t  ctrl
);
  import kbt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && (in_func != FUNC_NONE)) begin
          ctrl.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl.scan = 1'b1;
        if (stat.stop) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        ctrl.commit = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          if (stat.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/kbt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbt_datapath
// Binding table memory, scan pointer with registered read, match logic,
// update plan, list collection lanes and the output register.
// ----------------------------------------------------------------------------
module kbt_datapath #(
  parameter int TABLE_DEPTH     = 64,
  parameter int MAX_PER_COMMAND = 3,
  parameter int NUM_COMMANDS    = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  kbt_pkg::func_t                    in_func,
  input  logic [kbt_pkg::SYM_W-1:0]         in_symbol,
  input  logic [kbt_pkg::MOD_W-1:0]         in_modifiers,
  input  logic [kbt_pkg::CMD_W-1:0]         in_command,
  input  kbt_pkg::ctrl_t                    ctrl,
  output kbt_pkg::stat_t                    stat,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [kbt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [kbt_pkg::STATUS_W-1:0]      out_tuser,
  output logic                              out_tlast
);
  import kbt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = $clog2(MAX_PER_COMMAND + 1);
  localparam int LW = (MAX_PER_COMMAND > 1) ? $clog2(MAX_PER_COMMAND) : 1;

  entry_t            mem [TABLE_DEPTH];

  func_t             func_r;
  key_t              key_r;
  logic [CMD_W-1:0]  cmd_r;

  logic [CW-1:0]     addr_r;
  logic [CW-1:0]     count_r;
  logic              rd_vld_r;
  logic [AW-1:0]     rd_idx_r;
  entry_t            rd_ent_r;

  logic [NW-1:0]     seen_r;
  logic [AW-1:0]     first_r;
  logic [NW-1:0]     n_r;
  logic [NW-1:0]     k_r;
  key_t              lane_r [MAX_PER_COMMAND];

  logic              wr_en_r;
  logic              inc_r;
  logic [AW-1:0]     wr_addr_r;
  entry_t            wr_ent_r;
  status_t           status_r;
  logic [CMD_W-1:0]  found_r;

  logic              out_vld_r;
  status_t           o_status_r;
  logic [CMD_W-1:0]  o_found_r;
  key_t              o_key_r;
  logic              o_valid_r;
  logic [TOT_W-1:0]  o_total_r;
  logic              o_last_r;

  logic              cmd_ok;
  logic              more;
  logic              issue;
  logic              cmd_eq;
  logic              key_eq;
  logic              seen_full;
  logic              n_full;
  logic              scan_end;
  logic              hit;
  logic              is_list;
  logic              list_last;

  logic              plan_wr;
  logic              plan_inc;
  logic [AW-1:0]     plan_addr;
  status_t           plan_status;
  logic [CMD_W-1:0]  plan_found;

  assign cmd_ok    = (32'(cmd_r) < NUM_COMMANDS);
  assign more      = (addr_r < count_r);
  assign issue     = ctrl.scan && more;
  assign cmd_eq    = rd_vld_r && (rd_ent_r.cmd == cmd_r);
  assign key_eq    = rd_vld_r && (rd_ent_r.key == key_r);
  assign seen_full = (({1'b0, seen_r} + 1'b1) == (NW + 1)'(MAX_PER_COMMAND));
  assign n_full    = (({1'b0, n_r} + 1'b1) == (NW + 1)'(MAX_PER_COMMAND));
  assign scan_end  = !rd_vld_r && !more;
  assign is_list   = (func_r == FUNC_LIST);
  assign list_last = (n_r == '0) || (({1'b0, k_r} + 1'b1) == {1'b0, n_r});

  always_comb begin
    case (func_r)
      FUNC_ADD:    hit = !cmd_ok || (cmd_eq && seen_full) || (!cmd_eq && key_eq);
      FUNC_LOOKUP: hit = key_eq;
      FUNC_LIST:   hit = cmd_ok && cmd_eq && n_full;
      default:     hit = 1'b1;
    endcase
  end

  always_comb begin
    plan_wr     = 1'b0;
    plan_inc    = 1'b0;
    plan_addr   = rd_idx_r;
    plan_status = ST_QUERY;
    plan_found  = '0;
    case (func_r)
      FUNC_ADD: begin
        if (!cmd_ok) begin
          plan_status = ST_FULL;
        end else if (cmd_eq && seen_full) begin
          plan_wr     = 1'b1;
          plan_addr   = (seen_r == '0) ? rd_idx_r : first_r;
          plan_status = ST_REPLACED;
        end else if (!cmd_eq && key_eq) begin
          plan_wr     = 1'b1;
          plan_status = ST_REPLACED;
        end else if (count_r == CW'(TABLE_DEPTH)) begin
          plan_status = ST_FULL;
        end else begin
          plan_wr     = 1'b1;
          plan_inc    = 1'b1;
          plan_addr   = count_r[AW-1:0];
          plan_status = ST_APPENDED;
        end
      end
      FUNC_LOOKUP: begin
        if (key_eq) begin
          plan_found = rd_ent_r.cmd;
        end
      end
      default: begin
        plan_status = ST_QUERY;
      end
    endcase
  end

  assign stat.stop     = hit || scan_end;
  assign stat.last     = !is_list || list_last;
  assign stat.out_free = !out_vld_r || out_tready;

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.commit && wr_en_r) begin
      mem[wr_addr_r] <= wr_ent_r;
    end
    if (issue) begin
      rd_ent_r <= mem[addr_r[AW-1:0]];
      rd_idx_r <= addr_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      addr_r    <= '0;
      rd_vld_r  <= 1'b0;
      seen_r    <= '0;
      n_r       <= '0;
      k_r       <= '0;
      wr_en_r   <= 1'b0;
      inc_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (ctrl.load) begin
        addr_r  <= '0;
        seen_r  <= '0;
        n_r     <= '0;
        k_r     <= '0;
        wr_en_r <= 1'b0;
        inc_r   <= 1'b0;
      end
      if (issue) begin
        addr_r <= addr_r + 1'b1;
      end
      if (ctrl.scan && (func_r == FUNC_ADD) && cmd_eq) begin
        seen_r <= seen_r + 1'b1;
      end
      if (ctrl.scan && is_list && cmd_ok && cmd_eq) begin
        n_r <= n_r + 1'b1;
      end
      if (ctrl.scan && stat.stop) begin
        wr_en_r <= plan_wr;
        inc_r   <= plan_inc;
      end
      if (ctrl.commit && inc_r) begin
        count_r <= count_r + 1'b1;
      end
      if (ctrl.emit) begin
        k_r <= k_r + 1'b1;
      end
      if (ctrl.emit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      func_r        <= in_func;
      key_r.sym     <= in_symbol;
      key_r.mods    <= in_modifiers;
      cmd_r         <= in_command;
    end
    if (ctrl.scan && (func_r == FUNC_ADD) && cmd_eq && (seen_r == '0)) begin
      first_r <= rd_idx_r;
    end
    if (ctrl.scan && is_list && cmd_ok && cmd_eq) begin
      lane_r[n_r[LW-1:0]] <= rd_ent_r.key;
    end
    if (ctrl.scan && stat.stop) begin
      wr_addr_r    <= plan_addr;
      wr_ent_r.cmd <= cmd_r;
      wr_ent_r.key <= key_r;
      status_r     <= plan_status;
      found_r      <= plan_found;
    end
    if (ctrl.emit) begin
      o_status_r <= status_r;
      o_found_r  <= found_r;
      o_last_r   <= stat.last;
      if (is_list && (n_r != '0)) begin
        o_key_r   <= lane_r[k_r[LW-1:0]];
        o_valid_r <= 1'b1;
        o_total_r <= TOT_W'(n_r);
      end else begin
        o_key_r   <= '0;
        o_valid_r <= 1'b0;
        o_total_r <= '0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = o_status_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, o_total_r, o_valid_r, o_key_r.mods, o_key_r.sym,
                       o_found_r};

endmodule

// ===== tb/sv/key_binding_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_binding_table_checker
// Watches both item channels of the key binding table. Every accepted input
// item runs through a private copy of the binding table, which queues the
// result items it should cause; every accepted result item is compared field
// by field against the oldest queued one. Reports the mismatch count and the
// number of result items still outstanding.
// ----------------------------------------------------------------------------
module key_binding_table_checker #(
  parameter int TABLE_DEPTH     = 64,
  parameter int MAX_PER_COMMAND = 3,
  parameter int NUM_COMMANDS    = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [kbt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [kbt_pkg::FUNC_W-1:0]      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [kbt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [kbt_pkg::STATUS_W-1:0]    out_tuser,
  input  logic                            out_tlast,
  output int                              fail_count,
  output int                              results_owed
);
  import kbt_pkg::*;

  typedef struct {
    status_t          status;
    logic [CMD_W-1:0] found;
    logic [SYM_W-1:0] sym;
    logic [MOD_W-1:0] mods;
    logic             valid;
    logic [TOT_W-1:0] total;
    logic             last;
  } binding_result_t;

  logic [SYM_W-1:0] bind_sym  [TABLE_DEPTH];
  logic [MOD_W-1:0] bind_mods [TABLE_DEPTH];
  logic [CMD_W-1:0] bind_cmd  [TABLE_DEPTH];
  int               bind_count = 0;

  binding_result_t  owed_results[$];
  int               mismatches = 0;
  int               owed = 0;

  assign fail_count   = mismatches;
  assign results_owed = owed;

  function automatic binding_result_t make_result(status_t st, logic [CMD_W-1:0] found,
                                                  logic [SYM_W-1:0] sym,
                                                  logic [MOD_W-1:0] mods, logic valid,
                                                  logic [TOT_W-1:0] total, logic last);
    binding_result_t r;
    r.status = st;
    r.found  = found;
    r.sym    = sym;
    r.mods   = mods;
    r.valid  = valid;
    r.total  = total;
    r.last   = last;
    return r;
  endfunction

  function automatic status_t add_binding(logic [SYM_W-1:0] sym, logic [MOD_W-1:0] mods,
                                          logic [CMD_W-1:0] cmd);
    int first;
    int seen;
    int i;
    first = 0;
    seen  = 0;
    if (int'(cmd) >= NUM_COMMANDS) return ST_FULL;
    for (i = 0; i < bind_count; i++) begin
      if (bind_cmd[i] == cmd) begin
        if (seen == 0) first = i;
        seen++;
        if (seen == MAX_PER_COMMAND) begin
          bind_sym[first]  = sym;
          bind_mods[first] = mods;
          return ST_REPLACED;
        end
      end else if (bind_sym[i] == sym && bind_mods[i] == mods) begin
        bind_cmd[i] = cmd;
        return ST_REPLACED;
      end
    end
    if (bind_count >= TABLE_DEPTH) return ST_FULL;
    bind_sym[bind_count]  = sym;
    bind_mods[bind_count] = mods;
    bind_cmd[bind_count]  = cmd;
    bind_count++;
    return ST_APPENDED;
  endfunction

  function automatic logic [CMD_W-1:0] command_for_key(logic [SYM_W-1:0] sym,
                                                       logic [MOD_W-1:0] mods);
    int i;
    for (i = 0; i < bind_count; i++)
      if (bind_sym[i] == sym && bind_mods[i] == mods) return bind_cmd[i];
    return '0;
  endfunction

  task automatic predict_item(func_t op, logic [SYM_W-1:0] sym, logic [MOD_W-1:0] mods,
                              logic [CMD_W-1:0] cmd);
    int hits [MAX_PER_COMMAND];
    int n;
    int i;
    status_t st;
    n = 0;
    case (op)
      FUNC_ADD: begin
        st = add_binding(sym, mods, cmd);
        owed_results.push_back(make_result(st, '0, '0, '0, 1'b0, '0, 1'b1));
      end
      FUNC_LOOKUP: begin
        owed_results.push_back(make_result(ST_QUERY, command_for_key(sym, mods), '0, '0,
                                           1'b0, '0, 1'b1));
      end
      FUNC_LIST: begin
        if (int'(cmd) < NUM_COMMANDS)
          for (i = 0; i < bind_count && n < MAX_PER_COMMAND; i++)
            if (bind_cmd[i] == cmd) begin
              hits[n] = i;
              n++;
            end
        if (n == 0)
          owed_results.push_back(make_result(ST_QUERY, '0, '0, '0, 1'b0, '0, 1'b1));
        for (i = 0; i < n; i++)
          owed_results.push_back(make_result(ST_QUERY, '0, bind_sym[hits[i]],
                                             bind_mods[hits[i]], 1'b1, TOT_W'(n),
                                             i == n - 1));
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [SYM_W-1:0] want, logic [SYM_W-1:0] seen);
    if (seen !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      mismatches++;
    end
  endtask

  task automatic check_result();
    binding_result_t want;
    if (owed_results.size() == 0) begin
      $error("result item with no pending expectation: tdata 0x%0h tuser %0d",
             out_tdata, out_tuser);
      mismatches++;
    end else begin
      want = owed_results.pop_front();
      check_field("status", SYM_W'(want.status), SYM_W'(out_tuser));
      check_field("found_command", SYM_W'(want.found), SYM_W'(out_tdata[5:0]));
      check_field("bound_symbol", want.sym, out_tdata[21:6]);
      check_field("bound_modifiers", SYM_W'(want.mods), SYM_W'(out_tdata[29:22]));
      check_field("binding_valid", SYM_W'(want.valid), SYM_W'(out_tdata[30]));
      check_field("binding_total", SYM_W'(want.total), SYM_W'(out_tdata[32:31]));
      check_field("last_result", SYM_W'(want.last), SYM_W'(out_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready)
        predict_item(func_t'(in_tuser), in_tdata[15:0], in_tdata[23:16], in_tdata[29:24]);
    end
    owed <= owed_results.size();
  end

endmodule

// ===== tb/sv/key_binding_table_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_binding_table_unit_tb
// Drives add, lookup and list items into the key binding table: a directed
// opening over the edge cases, then random traffic drawn largely from small
// key and command pools so that rebinding, per-command overflow and a full
// table all occur. Sender and receiver stall at random in changing mixes.
// ----------------------------------------------------------------------------
module key_binding_table_unit_tb;
  import kbt_pkg::*;

  localparam int TABLE_DEPTH     = 64;
  localparam int MAX_PER_COMMAND = 3;
  localparam int NUM_COMMANDS    = 64;
  localparam int CYCLE_LIMIT     = 400000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]      in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   out_tlast;

  int fail_count;
  int results_owed;
  int cycles = 0;
  int send_idle_pct = 22;
  int recv_idle_pct = 77;
  int items_sent = 0;

  logic [SYM_W-1:0] sym_pool [8];
  logic [MOD_W-1:0] mod_pool [4];
  logic [CMD_W-1:0] cmd_pool [4];

  key_binding_table_unit #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .MAX_PER_COMMAND(MAX_PER_COMMAND),
    .NUM_COMMANDS   (NUM_COMMANDS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  key_binding_table_checker #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .MAX_PER_COMMAND(MAX_PER_COMMAND),
    .NUM_COMMANDS   (NUM_COMMANDS)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .results_owed(results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("key_binding_table_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic send_item(func_t op, logic [SYM_W-1:0] sym, logic [MOD_W-1:0] mods,
                           logic [CMD_W-1:0] cmd);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, cmd, mods, sym};
    do @(posedge clk); while (!in_tready);
    if (op != FUNC_NONE) items_sent++;
  endtask

  task automatic send_random();
    int pick;
    func_t op;
    logic [SYM_W-1:0] sym;
    logic [MOD_W-1:0] mods;
    logic [CMD_W-1:0] cmd;
    pick = $urandom_range(99);
    if (pick < 45) op = FUNC_ADD;
    else if (pick < 70) op = FUNC_LOOKUP;
    else if (pick < 95) op = FUNC_LIST;
    else op = FUNC_NONE;
    if ($urandom_range(99) < 70) begin
      sym  = sym_pool[$urandom_range(7)];
      mods = mod_pool[$urandom_range(3)];
    end else begin
      sym  = SYM_W'($urandom);
      mods = MOD_W'($urandom);
    end
    if ($urandom_range(1) == 1) cmd = cmd_pool[$urandom_range(3)];
    else cmd = CMD_W'($urandom_range(63));
    send_item(op, sym, mods, cmd);
  endtask

  initial begin
    int i;
    int target;
    sym_pool[0] = '0;
    sym_pool[1] = '1;
    for (i = 2; i < 8; i++) sym_pool[i] = SYM_W'($urandom);
    mod_pool[0] = '0;
    mod_pool[1] = '1;
    mod_pool[2] = MOD_W'($urandom);
    mod_pool[3] = MOD_W'($urandom);
    cmd_pool[0] = '0;
    cmd_pool[1] = CMD_W'(63);
    cmd_pool[2] = CMD_W'($urandom_range(1, 62));
    cmd_pool[3] = CMD_W'($urandom_range(1, 62));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, then rebinding, per-command overflow and a command pushed past its cap
    send_item(FUNC_LOOKUP, 16'h1234, 8'h5a, 6'd0);
    send_item(FUNC_LIST,   16'h0000, 8'h00, 6'd0);
    send_item(FUNC_ADD,    16'h0000, 8'h00, 6'd0);
    send_item(FUNC_ADD,    16'hffff, 8'hff, 6'd63);
    send_item(FUNC_LOOKUP, 16'hffff, 8'hff, 6'd0);
    send_item(FUNC_ADD,    16'hffff, 8'hff, 6'd5);
    send_item(FUNC_ADD,    16'h0001, 8'h01, 6'd5);
    send_item(FUNC_ADD,    16'h8000, 8'h80, 6'd5);
    send_item(FUNC_LIST,   16'h0000, 8'h00, 6'd5);
    send_item(FUNC_ADD,    16'h4242, 8'h24, 6'd5);
    send_item(FUNC_LOOKUP, 16'hffff, 8'hff, 6'd0);
    send_item(FUNC_ADD,    16'h0000, 8'h00, 6'd5);
    send_item(FUNC_LIST,   16'hffff, 8'hff, 6'd5);
    send_item(FUNC_NONE,   16'hffff, 8'hff, 6'd63);
    send_item(FUNC_LIST,   16'h0000, 8'h00, 6'd63);
    send_item(FUNC_LOOKUP, 16'h0000, 8'h00, 6'd63);
    send_item(FUNC_ADD,    16'h5555, 8'haa, 6'd42);
    send_item(FUNC_LIST,   16'h0000, 8'h00, 6'd42);

    target = items_sent + 120;
    while (items_sent < target) send_random();

    send_idle_pct = 77;
    recv_idle_pct = 22;
    // fill the table with fresh keys spread over all commands
    for (i = 0; i < 70; i++)
      send_item(FUNC_ADD, SYM_W'($urandom), MOD_W'($urandom), CMD_W'(i % NUM_COMMANDS));
    target = items_sent + 55;
    while (items_sent < target) send_random();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    target = items_sent + 110;
    while (items_sent < target) send_random();

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 40) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("key_binding_table_unit_tb: done, clean");
    end else begin
      $display("key_binding_table_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
